// ===== src/tsdc_pkg.sv =====
`timescale 1ns / 1ps
package tsdc_pkg;

	localparam int TABLE_SLOTS = 1024;
	localparam int MAX_GROUPS  = 4;
	localparam int IDX_W       = $clog2(TABLE_SLOTS);
	localparam int GROUP_BITS  = 16;
	localparam int GROUP_SLOTS = 4;
	localparam int HASH_BYTES  = 4;
	localparam int STEP_W      = $clog2(HASH_BYTES);

	localparam logic [31:0] FNV_OFFSET  = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME   = 32'd16777619;
	localparam logic [15:0] TTL_RESET   = 16'd10;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_STORE  = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [63:0] word_high;
		logic [63:0] word_low;
		logic [31:0] now_seconds;
		logic        need_group;
		logic        account_present;
		logic [2:0]  group_count;
		logic [63:0] group_list;
		logic [15:0] primary_group;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [63:0] found_high;
		logic [63:0] found_low;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [63:0] word_high;
		logic [63:0] word_low;
		logic [31:0] stamp;
		logic [2:0]  group_count;
		logic [63:0] groups;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic hash_step;
		logic mem_write;
		logic mem_read;
		logic check;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic hash_last;
		logic is_store;
	} status_t;

	function automatic logic [IDX_W-1:0] fnv_step(input logic [IDX_W-1:0] h,
			input logic [7:0] b);
		logic [IDX_W-1:0] x;
		x = h ^ IDX_W'(b);
		return x * FNV_PRIME[IDX_W-1:0];
	endfunction

	function automatic logic [2:0] clip_count(input logic [2:0] n);
		return (n > 3'(MAX_GROUPS)) ? 3'(MAX_GROUPS) : n;
	endfunction

endpackage

// ===== src/ttl_scoped_direct_mapped_cache.sv =====
`timescale 1ns / 1ps
// A lookup request is registered when accepted, hashed byte by byte into a slot index, read
// from the slot memory and checked; the registered result goes on rsp with result_valid high.
// A store gives no result; it writes the slot after the hash and then frees busy. Requests are
// served one at a time through the byte-serial slot hash and the registered slot memory read.
// After reset the block clears the valid bit of every slot, one per cycle, and holds busy high
// until every slot is cleared; the TTL register resets to 10 and may be written meanwhile.
module ttl_scoped_direct_mapped_cache (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tsdc_pkg::req_t   req,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata,
	output logic             result_valid,
	output tsdc_pkg::rsp_t   rsp
);
	import tsdc_pkg::*;

	cmd_t    cmd;
	status_t status;

	tsdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	tsdc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req          (req),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.rsp          (rsp)
	);

endmodule

// ===== src/tsdc_ctrl.sv =====
`timescale 1ns / 1ps
module tsdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tsdc_pkg::status_t status,
	output tsdc_pkg::cmd_t    cmd,
	output logic              busy
);
	import tsdc_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_HASH   = 5'b00100,
		S_ACCESS = 5'b01000,
		S_CHECK  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		busy       = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) begin
					state_next = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load   = 1'b1;
					state_next = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (status.hash_last) begin
					state_next = S_ACCESS;
				end
			end
			S_ACCESS: begin
				if (status.is_store) begin
					cmd.mem_write = 1'b1;
					state_next    = S_IDLE;
				end else begin
					cmd.mem_read = 1'b1;
					state_next   = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check  = 1'b1;
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_CLEAR;
			end
		endcase
	end

endmodule

// ===== src/tsdc_dp.sv =====
`timescale 1ns / 1ps
module tsdc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  tsdc_pkg::cmd_t    cmd,
	output tsdc_pkg::status_t status,
	input  tsdc_pkg::req_t    req,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	output logic              result_valid,
	output tsdc_pkg::rsp_t    rsp
);
	import tsdc_pkg::*;

	entry_t mem [TABLE_SLOTS];

	req_t              req_q;
	entry_t            rd_q;
	logic [IDX_W-1:0]  hash_q;
	logic [STEP_W-1:0] step_q;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic [15:0]       ttl_q;
	logic              valid_q;
	rsp_t              rsp_q;

	logic [31:0]       key_top;
	logic [7:0]        hash_byte;
	logic [2:0]        req_count;
	logic [63:0]       kept;
	entry_t            wr_entry;
	logic [IDX_W-1:0]  wr_addr;
	logic              wr_en;

	logic [31:0]       age;
	logic              fresh;
	logic              key_match;
	logic              primary_match;
	logic              any_match;
	logic              group_ok;
	logic              hit;

	assign key_top   = req_q.key_high[63:32];
	assign hash_byte = key_top[{~step_q, 3'b000} +: 8];
	assign req_count = clip_count(req_q.group_count);

	always_comb begin
		kept = '0;
		for (int i = 0; i < GROUP_SLOTS; i++) begin
			if (3'(i) < req_count) begin
				kept[i*GROUP_BITS +: GROUP_BITS] = req_q.group_list[i*GROUP_BITS +: GROUP_BITS];
			end
		end
	end

	always_comb begin
		wr_entry             = '0;
		wr_entry.valid       = 1'b1;
		wr_entry.key_high    = req_q.key_high;
		wr_entry.key_low     = req_q.key_low;
		wr_entry.word_high   = req_q.word_high;
		wr_entry.word_low    = req_q.word_low;
		wr_entry.stamp       = req_q.now_seconds;
		wr_entry.group_count = req_count;
		wr_entry.groups      = kept;
		if (cmd.clear) begin
			wr_entry = '0;
		end
	end

	assign wr_addr = cmd.clear ? clr_cnt_q : hash_q;
	assign wr_en   = cmd.clear | cmd.mem_write;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (cmd.mem_read) begin
			rd_q <= mem[hash_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q    <= '0;
			step_q    <= '0;
			clr_cnt_q <= '0;
			ttl_q     <= TTL_RESET;
		end else begin
			if (cmd.load) begin
				hash_q <= FNV_OFFSET[IDX_W-1:0];
				step_q <= '0;
			end else if (cmd.hash_step) begin
				hash_q <= fnv_step(hash_q, hash_byte);
				step_q <= step_q + 1'b1;
			end
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cfg_we) begin
				ttl_q <= cfg_wdata;
			end
		end
	end

	assign status.clear_last = (clr_cnt_q == '1);
	assign status.hash_last  = (step_q == STEP_W'(HASH_BYTES - 1));
	assign status.is_store   = (req_q.opcode == OP_STORE);

	assign age       = req_q.now_seconds - rd_q.stamp;
	assign fresh     = age[31] | (age < {16'd0, ttl_q});
	assign key_match = (rd_q.key_high == req_q.key_high) && (rd_q.key_low == req_q.key_low);

	always_comb begin
		primary_match = 1'b0;
		any_match     = 1'b0;
		for (int j = 0; j < GROUP_SLOTS; j++) begin
			if (3'(j) < rd_q.group_count) begin
				if (rd_q.groups[j*GROUP_BITS +: GROUP_BITS] == req_q.primary_group) begin
					primary_match = 1'b1;
				end
				for (int i = 0; i < GROUP_SLOTS; i++) begin
					if ((3'(i) < req_count) && (rd_q.groups[j*GROUP_BITS +: GROUP_BITS] ==
							req_q.group_list[i*GROUP_BITS +: GROUP_BITS])) begin
						any_match = 1'b1;
					end
				end
			end
		end
	end

	assign group_ok = req_q.account_present && (rd_q.group_count != 3'd0) &&
		((req_count != 3'd0) ? any_match : primary_match);
	assign hit = rd_q.valid && key_match && fresh && (!req_q.need_group || group_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.check;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			rsp_q.hit        <= hit;
			rsp_q.found_high <= hit ? rd_q.word_high : 64'd0;
			rsp_q.found_low  <= hit ? rd_q.word_low : 64'd0;
		end
	end

	assign result_valid = valid_q;
	assign rsp          = rsp_q;

endmodule

// ===== dv/ttl_scoped_direct_mapped_cache_test.sv =====
`timescale 1ns / 1ps
module ttl_scoped_direct_mapped_cache_test;
	import tsdc_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int PHASE_ITEMS = 290;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] K1_HI = 64'h0123_4567_89AB_CDEF;
	localparam logic [63:0] K1_LO = 64'hFEDC_BA98_7654_3210;
	localparam logic [63:0] K2_HI = 64'h0123_4567_0000_0001;

	typedef struct {
		logic [63:0] kh;
		logic [63:0] kl;
		logic [31:0] stamp;
	} key_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic result_valid;
	rsp_t rsp;

	req_t pending[$];
	rsp_t lookup_answers[$];
	key_rec_t stored_keys[$];
	entry_t cache_image[TABLE_SLOTS];
	logic [15:0] ttl_image;
	logic req_taken = 1'b0;
	int errors = 0;
	int burst_left = 1;
	int gap_left = 0;
	int idle_cycles = 0;

	ttl_scoped_direct_mapped_cache DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result_valid(result_valid),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	task automatic report(input string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	function automatic logic [IDX_W-1:0] slot_for(input logic [63:0] kh);
		logic [31:0] h;
		int b;
		h = FNV_OFFSET;
		for (b = 0; b < 4; b++)
			h = (h ^ {24'd0, kh[63 - 8 * b -: 8]}) * FNV_PRIME;
		return h[IDX_W-1:0];
	endfunction

	function automatic bit serve_request(input req_t r, output rsp_t ans);
		logic [IDX_W-1:0] idx;
		entry_t e;
		logic [31:0] age;
		logic [63:0] kept;
		int cnt;
		int scnt;
		int i;
		int j;
		bit fresh;
		bit permitted;
		idx = slot_for(r.key_high);
		cnt = (r.group_count > MAX_GROUPS) ? MAX_GROUPS : r.group_count;
		ans = '0;
		if (r.opcode == OP_STORE) begin
			kept = '0;
			for (i = 0; i < cnt; i++)
				kept[GROUP_BITS * i +: GROUP_BITS] = r.group_list[GROUP_BITS * i +: GROUP_BITS];
			e.valid = 1'b1;
			e.key_high = r.key_high;
			e.key_low = r.key_low;
			e.word_high = r.word_high;
			e.word_low = r.word_low;
			e.stamp = r.now_seconds;
			e.group_count = 3'(cnt);
			e.groups = kept;
			cache_image[idx] = e;
			return 1'b0;
		end
		e = cache_image[idx];
		if (e.valid && e.key_high == r.key_high && e.key_low == r.key_low) begin
			age = r.now_seconds - e.stamp;
			fresh = age[31] || (age < {16'd0, ttl_image});
			permitted = 1'b0;
			scnt = e.group_count;
			if (r.account_present && scnt > 0) begin
				if (cnt > 0) begin
					for (i = 0; i < cnt; i++)
						for (j = 0; j < scnt; j++)
							if (r.group_list[GROUP_BITS * i +: GROUP_BITS] ==
									e.groups[GROUP_BITS * j +: GROUP_BITS])
								permitted = 1'b1;
				end else begin
					for (j = 0; j < scnt; j++)
						if (r.primary_group == e.groups[GROUP_BITS * j +: GROUP_BITS])
							permitted = 1'b1;
				end
			end
			if (fresh && (!r.need_group || permitted)) begin
				ans.hit = 1'b1;
				ans.found_high = e.word_high;
				ans.found_low = e.word_low;
			end
		end
		return 1'b1;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [15:0] rand_group();
		return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
	endfunction

	function automatic req_t pack_request(input logic op, input logic [63:0] kh,
			input logic [63:0] kl, input logic [63:0] wh, input logic [63:0] wl,
			input logic [31:0] now, input logic need, input logic present,
			input logic [2:0] cnt, input logic [63:0] list, input logic [15:0] primary);
		req_t r;
		r.opcode = op;
		r.key_high = kh;
		r.key_low = kl;
		r.word_high = wh;
		r.word_low = wl;
		r.now_seconds = now;
		r.need_group = need;
		r.account_present = present;
		r.group_count = cnt;
		r.group_list = list;
		r.primary_group = primary;
		return r;
	endfunction

	function automatic req_t make_request(input logic [15:0] ttl);
		req_t r;
		key_rec_t k;
		bit have_key;
		int t;
		logic [31:0] delta;
		logic [5:0] flip_pos;
		t = ttl;
		r = pack_request(OP_LOOKUP, rand64(), rand64(), rand64(), rand64(), $urandom,
			1'($urandom_range(0, 1)), ($urandom_range(0, 4) != 0), 3'($urandom_range(0, 7)),
			{rand_group(), rand_group(), rand_group(), rand_group()}, rand_group());
		have_key = stored_keys.size() > 0;
		if (have_key)
			k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
		if (!have_key || $urandom_range(0, 99) < 40) begin
			r.opcode = OP_STORE;
			case ($urandom_range(0, 9))
				0, 1, 2: if (have_key) begin
					r.key_high = k.kh;
					r.key_low = k.kl;
				end
				3, 4: if (have_key)
					r.key_high[63:32] = k.kh[63:32];
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0: r.now_seconds = 32'h0000_0000;
				1: r.now_seconds = 32'hFFFF_FFFF;
				default: ;
			endcase
			stored_keys.push_back('{r.key_high, r.key_low, r.now_seconds});
			if (stored_keys.size() > 48)
				void'(stored_keys.pop_front());
		end else if (have_key && $urandom_range(0, 9) < 8) begin
			r.key_high = k.kh;
			r.key_low = k.kl;
			case ($urandom_range(0, 19))
				0: begin
					flip_pos = 6'($urandom_range(0, 63));
					r.key_low[flip_pos] = ~r.key_low[flip_pos];
				end
				1: begin
					flip_pos = 6'($urandom_range(0, 31));
					r.key_high[flip_pos] = ~r.key_high[flip_pos];
				end
				default: ;
			endcase
			case ($urandom_range(0, 7))
				0, 1, 2, 3: delta = $urandom_range(0, t - 1);
				4: delta = t + $urandom_range(0, 3);
				5: delta = 32'd0 - $urandom_range(1, 1000);
				6: delta = $urandom;
				default: delta = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			endcase
			r.now_seconds = k.stamp + delta;
		end
		return r;
	endfunction

	task automatic wait_idle();
		while (pending.size() > 0 || start || lookup_answers.size() > 0 || busy)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_ttl(input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || req_taken) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending.size() > 0) begin
				req <= pending.pop_front();
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		rsp_t ans;
		rsp_t want;
		if (!arst_n) begin
			foreach (cache_image[i])
				cache_image[i].valid = 1'b0;
			ttl_image = TTL_RESET;
			req_taken <= 1'b0;
		end else begin
			if (result_valid) begin
				if (lookup_answers.size() == 0) begin
					report("result with no lookup pending");
				end else begin
					want = lookup_answers.pop_front();
					if (rsp.hit !== want.hit)
						report($sformatf("hit %b, expected %b", rsp.hit, want.hit));
					if (rsp.found_high !== want.found_high)
						report($sformatf("found_high %h, expected %h", rsp.found_high,
							want.found_high));
					if (rsp.found_low !== want.found_low)
						report($sformatf("found_low %h, expected %h", rsp.found_low,
							want.found_low));
				end
			end
			if (cfg_we)
				ttl_image = cfg_wdata;
			req_taken <= start && !busy;
			if (start && !busy && serve_request(req, ans))
				lookup_answers.push_back(ans);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] ttl_plan[6];
		int p;
		int n;
		ttl_plan = '{16'd1, 16'd65535, 16'd2, 16'd300, 16'($urandom_range(1, 65535)), 16'd10};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests run under the reset TTL of 10.
		pending.push_back(pack_request(OP_LOOKUP, ONES, ONES, 0, 0, 32'hFFFF_FFFF, 1, 1, 7,
			ONES, 16'hFFFF));
		pending.push_back(pack_request(OP_STORE, K1_HI, K1_LO, ONES, 0, 100, 0, 0, 2,
			{16'd9, 16'd9, 16'd7, 16'd5}, 0));
		pending.push_back(pack_request(OP_LOOKUP, K1_HI, K1_LO, 0, 0, 100, 0, 1, 0, 0, 0));
		pending.push_back(pack_request(OP_LOOKUP, K1_HI, K1_LO, 0, 0, 109, 0, 1, 0, 0, 0));
		pending.push_back(pack_request(OP_LOOKUP, K1_HI, K1_LO, 0, 0, 110, 0, 1, 0, 0, 0));
		pending.push_back(pack_request(OP_LOOKUP, K1_HI, K1_LO, 0, 0, 50, 0, 1, 0, 0, 0));
		pending.push_back(pack_request(OP_LOOKUP, K1_HI, K1_LO ^ 64'd1, 0, 0, 100, 0, 1, 0,
			0, 0));
		pending.push_back(pack_request(OP_LOOKUP, K2_HI, K1_LO, 0, 0, 100, 0, 1, 0, 0, 0));
		pending.push_back(pack_request(OP_LOOKUP, K1_HI, K1_LO, 0, 0, 100, 1, 0, 1, 5, 5));
		pending.push_back(pack_request(OP_LOOKUP, K1_HI, K1_LO, 0, 0, 100, 1, 1, 0, 0, 7));
		pending.push_back(pack_request(OP_LOOKUP, K1_HI, K1_LO, 0, 0, 100, 1, 1, 0, 0, 9));
		pending.push_back(pack_request(OP_LOOKUP, K1_HI, K1_LO, 0, 0, 100, 1, 1, 7,
			{16'd7, 16'd3, 16'd2, 16'd1}, 0));
		pending.push_back(pack_request(OP_LOOKUP, K1_HI, K1_LO, 0, 0, 100, 1, 1, 1,
			{16'd7, 16'd7, 16'd7, 16'd1}, 0));
		pending.push_back(pack_request(OP_STORE, 0, 0, 64'hA5A5_A5A5_A5A5_A5A5,
			64'h5A5A_5A5A_5A5A_5A5A, 32'hFFFF_FFF0, 1, 1, 0, ONES, 16'hFFFF));
		pending.push_back(pack_request(OP_LOOKUP, 0, 0, 0, 0, 32'hFFFF_FFF9, 0, 0, 0, 0, 0));
		pending.push_back(pack_request(OP_LOOKUP, 0, 0, 0, 0, 5, 0, 0, 0, 0, 0));
		pending.push_back(pack_request(OP_LOOKUP, 0, 0, 0, 0, 32'hFFFF_FFF0, 1, 1, 1, ONES,
			16'hFFFF));
		pending.push_back(pack_request(OP_STORE, K2_HI, K1_LO, 64'h1111_2222_3333_4444,
			ONES, 1000, 0, 0, 7, {16'd4, 16'd3, 16'd2, 16'd1}, 0));
		pending.push_back(pack_request(OP_LOOKUP, K1_HI, K1_LO, 0, 0, 1000, 0, 1, 0, 0, 0));
		pending.push_back(pack_request(OP_LOOKUP, K2_HI, K1_LO, 0, 0, 1000, 1, 1, 2,
			{16'd0, 16'd0, 16'd9, 16'd4}, 0));
		pending.push_back(pack_request(OP_LOOKUP, K2_HI, K1_LO, 0, 0, 1009, 0, 1, 0, 0, 0));
		pending.push_back(pack_request(OP_LOOKUP, K2_HI, K1_LO, 0, 0, 1010, 0, 1, 0, 0, 0));
		wait_idle();

		for (p = 0; p < 6; p++) begin
			set_ttl(ttl_plan[p]);
			for (n = 0; n < PHASE_ITEMS; n++)
				pending.push_back(make_request(ttl_plan[p]));
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
